@@ hdl/halfsiphash_2_4_hasher_macros.svh @@
// Assertion macros for the HalfSipHash-2-4 hasher.
// Included by the top level; no other dependencies.
`ifndef HALFSIPHASH_2_4_HASHER_MACROS_SVH
`define HALFSIPHASH_2_4_HASHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define HSH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HSH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define HSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/hsh_pkg.sv @@
// Shared types, constants and the control store of the HalfSipHash-2-4 hasher.
// No dependencies.
`default_nettype none

package hsh_pkg;

    // Field widths.
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;
    localparam int LEN_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    // Algorithm constants.
    localparam logic [WORD_W-1:0] LANE_INIT_TWO   = 32'h6c796765;
    localparam logic [WORD_W-1:0] LANE_INIT_THREE = 32'h74656462;
    localparam logic [WORD_W-1:0] FINAL_MARK      = 32'h000000ff;
    localparam logic [LEN_W-1:0]  FULL_WORD_BYTES = 8'd4;

    // Step counter and program addresses.
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE      = 4'd0;
    localparam pc_t STEP_RND_A     = 4'd1;
    localparam pc_t STEP_RND_FOLD  = 4'd2;
    localparam pc_t STEP_RND_MARK  = 4'd3;
    localparam pc_t STEP_FIN_B     = 4'd4;
    localparam pc_t STEP_FIN_C     = 4'd5;
    localparam pc_t STEP_FIN_D     = 4'd6;
    localparam pc_t STEP_EMIT      = 4'd7;
    localparam pc_t STEP_TAIL_IN   = 4'd8;

    // Sequencing kinds.
    typedef enum logic [2:0] {
        BR_NEXT,      // fall through to the next step
        BR_GOTO,      // jump to the target
        BR_HOLD_IN,   // stay until a word is taken, then fall through
        BR_WORD,      // end of a compression: idle, tail block or finalization
        BR_HOLD_OUT   // stay until the result slot is free, then jump
    } br_t;

    // One control word.
    typedef struct packed {
        logic take;   // input channel is open in this step
        logic rnd;    // run one SipRound
        logic mark;   // v2 ^= 0xff ahead of the round
        logic fold;   // v0 ^= m after the round
        logic tail;   // absorb the length-only tail block into v3
        logic emit;   // hand v1 ^ v3 to the result register
        br_t  br;
        pc_t  target;
    } ucode_t;

    // Branch status from the datapath and the handshakes.
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic last;
        logic full;
    } seq_status_t;

    // The control store.
    function automatic ucode_t hsh_rom(input pc_t pc);
        ucode_t u;
        u = '{take: 1'b0, rnd: 1'b0, mark: 1'b0, fold: 1'b0, tail: 1'b0,
              emit: 1'b0, br: BR_GOTO, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:
            begin
                u.take = 1'b1;
                u.br   = BR_HOLD_IN;
            end
            STEP_RND_A:
            begin
                u.rnd = 1'b1;
                u.br  = BR_NEXT;
            end
            STEP_RND_FOLD:
            begin
                u.rnd    = 1'b1;
                u.fold   = 1'b1;
                u.br     = BR_WORD;
                u.target = STEP_TAIL_IN;
            end
            STEP_RND_MARK:
            begin
                u.rnd  = 1'b1;
                u.mark = 1'b1;
                u.br   = BR_NEXT;
            end
            STEP_FIN_B, STEP_FIN_C, STEP_FIN_D:
            begin
                u.rnd = 1'b1;
                u.br  = BR_NEXT;
            end
            STEP_EMIT:
            begin
                u.emit   = 1'b1;
                u.br     = BR_HOLD_OUT;
                u.target = STEP_IDLE;
            end
            STEP_TAIL_IN:
            begin
                u.tail   = 1'b1;
                u.br     = BR_GOTO;
                u.target = STEP_RND_A;
            end
            default:
            begin
                u.br     = BR_GOTO;
                u.target = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ hdl/hsh_channels.sv @@
// Handshake channel interfaces of the HalfSipHash-2-4 hasher.
// Depends on hsh_pkg for field widths.
`default_nettype none

// Message words in.
interface hsh_word_if;
    logic                              valid;
    logic                              ready;
    logic [hsh_pkg::WORD_W-1:0]        word_data;
    logic [hsh_pkg::COUNT_W-1:0]       byte_count;
    logic                              last;

    modport source (output valid, word_data, byte_count, last, input ready);
    modport sink   (input valid, word_data, byte_count, last, output ready);
endinterface

// Hash results out.
interface hsh_hash_if;
    logic                              valid;
    logic                              ready;
    logic [hsh_pkg::WORD_W-1:0]        hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

// Key register writes.
interface hsh_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hsh_pkg::CFG_IDX_W-1:0]     index;
    logic [hsh_pkg::WORD_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/hsh_sequencer.sv @@
// Step counter and control store lookup of the HalfSipHash-2-4 hasher.
// Depends on hsh_pkg.
`default_nettype none

module hsh_sequencer (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire hsh_pkg::seq_status_t  status,
    output hsh_pkg::ucode_t            ctrl
);

    hsh_pkg::pc_t pc_reg;
    hsh_pkg::pc_t pc_next;
    hsh_pkg::pc_t pc_inc;

    // Fetch the control word for the current step.
    assign ctrl   = hsh_pkg::hsh_rom(pc_reg);
    assign pc_inc = pc_reg + hsh_pkg::pc_t'(1);

    // Next step selection.
    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctrl.br)
            hsh_pkg::BR_NEXT:
            begin
                pc_next = pc_inc;
            end
            hsh_pkg::BR_GOTO:
            begin
                pc_next = ctrl.target;
            end
            hsh_pkg::BR_HOLD_IN:
            begin
                pc_next = status.in_fire ? pc_inc : pc_reg;
            end
            hsh_pkg::BR_WORD:
            begin
                priority if (!status.last)
                    pc_next = hsh_pkg::STEP_IDLE;
                else if (status.full)
                    pc_next = ctrl.target;
                else
                    pc_next = pc_inc;
            end
            hsh_pkg::BR_HOLD_OUT:
            begin
                pc_next = status.out_free ? ctrl.target : pc_reg;
            end
            default:
            begin
                pc_next = hsh_pkg::STEP_IDLE;
            end
        endcase
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= hsh_pkg::STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

@@ hdl/hsh_datapath.sv @@
// Lane registers, message block forming and SipRound unit of the hasher.
// Depends on hsh_pkg; driven by control words from hsh_sequencer.
`default_nettype none

module hsh_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire hsh_pkg::ucode_t             ctrl,
    input  wire                              in_fire,
    input  wire                              emit_fire,
    input  wire [hsh_pkg::WORD_W-1:0]        word_data,
    input  wire [hsh_pkg::COUNT_W-1:0]       byte_count,
    input  wire                              last,
    input  wire [hsh_pkg::WORD_W-1:0]        key_low,
    input  wire [hsh_pkg::WORD_W-1:0]        key_high,
    output logic                             last_flag,
    output logic                             full_flag,
    output logic [hsh_pkg::WORD_W-1:0]       hash
);

    localparam int W = hsh_pkg::WORD_W;
    localparam int L = hsh_pkg::LEN_W;

    typedef logic [W-1:0] lane_t;
    typedef logic [L-1:0] len_t;

    lane_t v0_reg, v1_reg, v2_reg, v3_reg;
    lane_t v0_next, v1_next, v2_next, v3_next;
    lane_t m_reg, m_next;
    len_t  len_reg, len_next;
    logic  in_msg_reg, in_msg_next;
    logic  last_reg, last_next;
    logic  full_reg, full_next;

    len_t  base_len;
    len_t  tail_len;
    logic  word_full;
    lane_t byte_mask;
    lane_t m_word;
    lane_t m_tail;
    lane_t r0, r1, r2, r3;
    lane_t v2_round_in;

    // Rotate a lane left.
    function automatic lane_t rotl(input lane_t x, input int n);
        return (x << n) | (x >> (W - n));
    endfunction

    // Message block of an accepted word.
    always_comb
    begin
        base_len  = in_msg_reg ? len_reg : '0;
        word_full = !last || byte_count[2];
        tail_len  = base_len + len_t'(byte_count[1:0]);
        unique case (byte_count[1:0])
            2'd0:    byte_mask = 32'h00000000;
            2'd1:    byte_mask = 32'h000000ff;
            2'd2:    byte_mask = 32'h0000ffff;
            default: byte_mask = 32'h00ffffff;
        endcase
        m_word = word_full ? word_data : ({tail_len, 24'h000000} | (word_data & byte_mask));
        m_tail = {len_reg, 24'h000000};
    end

    // SipRound, with the finalization mark folded into its v2 input.
    always_comb
    begin
        lane_t a, b, c, d;
        v2_round_in = ctrl.mark ? (v2_reg ^ hsh_pkg::FINAL_MARK) : v2_reg;
        a = v0_reg;
        b = v1_reg;
        c = v2_round_in;
        d = v3_reg;
        a = a + b;  b = rotl(b, 5);  b = b ^ a;  a = rotl(a, 16);
        c = c + d;  d = rotl(d, 8);  d = d ^ c;
        a = a + d;  d = rotl(d, 7);  d = d ^ a;
        c = c + b;  b = rotl(b, 13); b = b ^ c;  c = rotl(c, 16);
        r0 = a;
        r1 = b;
        r2 = c;
        r3 = d;
    end

    // Next lane and bookkeeping values.
    always_comb
    begin
        v0_next     = v0_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        v3_next     = v3_reg;
        m_next      = m_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        last_next   = last_reg;
        full_next   = full_reg;
        priority if (in_fire)
        begin
            // Load lanes from the key at message start, then absorb into v3.
            if (!in_msg_reg)
            begin
                v0_next = key_low;
                v1_next = key_high;
                v2_next = hsh_pkg::LANE_INIT_TWO ^ key_low;
                v3_next = hsh_pkg::LANE_INIT_THREE ^ key_high ^ m_word;
            end
            else
            begin
                v3_next = v3_reg ^ m_word;
            end
            m_next      = m_word;
            len_next    = word_full ? (base_len + hsh_pkg::FULL_WORD_BYTES) : tail_len;
            in_msg_next = 1'b1;
            last_next   = last;
            full_next   = word_full;
        end
        else if (ctrl.tail)
        begin
            // Length-only tail block after a four-byte last word.
            v3_next   = v3_reg ^ m_tail;
            m_next    = m_tail;
            full_next = 1'b0;
        end
        else if (ctrl.rnd)
        begin
            v0_next = ctrl.fold ? (r0 ^ m_reg) : r0;
            v1_next = r1;
            v2_next = r2;
            v3_next = r3;
        end
        else if (emit_fire)
        begin
            in_msg_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
            len_reg    <= '0;
            last_reg   <= 1'b0;
            full_reg   <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
            len_reg    <= len_next;
            last_reg   <= last_next;
            full_reg   <= full_next;
        end
    end

    // Lanes and message block.
    always_ff @(posedge clk)
    begin
        v0_reg <= v0_next;
        v1_reg <= v1_next;
        v2_reg <= v2_next;
        v3_reg <= v3_next;
        m_reg  <= m_next;
    end

    assign last_flag = last_reg;
    assign full_flag = full_reg;
    assign hash      = v1_reg ^ v3_reg;

endmodule

`default_nettype wire

@@ hdl/halfsiphash_2_4_hasher.sv @@
// Top level of the keyed HalfSipHash-2-4 hasher with a 32-bit result.
// Depends on hsh_pkg, hsh_channels, hsh_sequencer, hsh_datapath and the macro header.
//
//   channel    dir  payload                             words
//   word_in    in   word_data[31:0] byte_count[2:0] last  one per message word
//   hash_out   out  hash_value[31:0]                    one per message
//   cfg        in   index[1:0] data[31:0]               key register writes
//
// A word that is not last passes the take step, then two SipRounds; a last word then
// also runs the finalization SipRounds and the emit step, with a length-only tail block
// and two more SipRounds first at four bytes; the control store runs one SipRound unit.
// A full result register stalls only the emit step; the next word is taken after it.
// Reset drops a partial message and clears the keys; cfg is always ready.
`default_nettype none

`include "halfsiphash_2_4_hasher_macros.svh"

module halfsiphash_2_4_hasher (
    input  wire            clk,
    input  wire            rst_n,
    hsh_word_if.sink       word_in,
    hsh_hash_if.source     hash_out,
    hsh_cfg_if.sink        cfg
);

    hsh_pkg::ucode_t               ctrl;
    hsh_pkg::seq_status_t          status;
    logic                          in_fire;
    logic                          out_free;
    logic                          emit_fire;
    logic                          last_flag;
    logic                          full_flag;
    logic [hsh_pkg::WORD_W-1:0]    hash;
    logic [hsh_pkg::WORD_W-1:0]    key_low_reg;
    logic [hsh_pkg::WORD_W-1:0]    key_high_reg;
    logic [hsh_pkg::WORD_W-1:0]    hash_reg;
    logic                          hash_valid_reg;
    logic                          hash_valid_next;

    // Handshake decode.
    assign word_in.ready = ctrl.take;
    assign in_fire       = word_in.valid && ctrl.take;
    assign out_free      = !hash_valid_reg || hash_out.ready;
    assign emit_fire     = ctrl.emit && out_free;
    assign cfg.ready     = 1'b1;

    assign status = '{in_fire: in_fire, out_free: out_free,
                      last: last_flag, full: full_flag};

    hsh_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    hsh_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_fire    (in_fire),
        .emit_fire  (emit_fire),
        .word_data  (word_in.word_data),
        .byte_count (word_in.byte_count),
        .last       (word_in.last),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .last_flag  (last_flag),
        .full_flag  (full_flag),
        .hash       (hash)
    );

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == hsh_pkg::REG_KEY_LOW)
                key_low_reg <= cfg.data;
            if (cfg.index == hsh_pkg::REG_KEY_HIGH)
                key_high_reg <= cfg.data;
        end
    end

    // Result register.
    always_comb
    begin
        hash_valid_next = hash_valid_reg;
        priority if (emit_fire)
            hash_valid_next = 1'b1;
        else if (hash_out.ready)
            hash_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_valid_reg <= 1'b0;
        else
            hash_valid_reg <= hash_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
            hash_reg <= hash;
    end

    assign hash_out.valid      = hash_valid_reg;
    assign hash_out.hash_value = hash_reg;

    // A taken word starts the rounds, so the input closes in the next cycle.
    `HSH_ASSERT_NEXT(a_take_closes, clk, rst_n, in_fire, !word_in.ready, "input open after a take")
    // An emitted hash shows up as a valid result in the next cycle.
    `HSH_ASSERT_NEXT(a_emit_valid, clk, rst_n, emit_fire, hash_out.valid, "emitted hash not valid")
    // A blocked emit step holds until the result slot frees.
    `HSH_ASSERT_NEXT(a_emit_holds, clk, rst_n, ctrl.emit && !out_free, ctrl.emit, "emit step lost")

endmodule

`default_nettype wire
